/* rtl/core/u3hb_pkg.sv */
// package for the uniform 3d histogram binner: types, constants and helpers
package u3hb_pkg;

    localparam int MAX_BINS_X_DEF = 16;
    localparam int MAX_BINS_Y_DEF = 16;
    localparam int MAX_BINS_Z_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 32;
    localparam int COORD_W    = 32;
    localparam int WIDTH_W    = 31;
    localparam int BCNT_W     = 15;
    localparam int RIDX_W     = 4;
    localparam int QUO_W      = 33;

    localparam logic [CNT_W-1:0] SAT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_BIN   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_MIN_X   = 3'd0,
        CFG_MIN_Y   = 3'd1,
        CFG_MIN_Z   = 3'd2,
        CFG_WIDTH_X = 3'd3,
        CFG_WIDTH_Y = 3'd4,
        CFG_WIDTH_Z = 3'd5,
        CFG_BCOUNTS = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV   = 2'd1,
        ST_CLEAR = 2'd2,
        ST_EXEC  = 2'd3
    } t_front_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/core/uniform_3d_histogram_binner_unit.sv */
// top level of the uniform 3d histogram binner
// a new item is taken only while the front is idle; a bin item first runs the 33-step serial divider
// a clear blocks new items while it sweeps all MAX_BINS_X*MAX_BINS_Y*MAX_BINS_Z memory words
// reset: synchronous active low, followed by the same clearing sweep of the bin memory
module uniform_3d_histogram_binner_unit #(
    parameter int MAX_BINS_X = u3hb_pkg::MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = u3hb_pkg::MAX_BINS_Y_DEF,
    parameter int MAX_BINS_Z = u3hb_pkg::MAX_BINS_Z_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_action,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_z,
    input  logic [u3hb_pkg::RIDX_W-1:0]         i_read_bin_x,
    input  logic [u3hb_pkg::RIDX_W-1:0]         i_read_bin_y,
    input  logic [u3hb_pkg::RIDX_W-1:0]         i_read_bin_z,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_hit,
    output logic [u3hb_pkg::CNT_W-1:0]          o_bin_count,
    output logic [u3hb_pkg::CNT_W-1:0]          o_binned_total,
    output logic [u3hb_pkg::CNT_W-1:0]          o_missed_total,
    input  logic                                i_cfg_we,
    input  logic [u3hb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [u3hb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y * MAX_BINS_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0] r_min_x, r_min_y, r_min_z;
    logic [30:0] r_width_x, r_width_y, r_width_z;
    logic [14:0] r_bin_counts;
    logic cmd_valid, cmd_ready, cmd_ok;
    logic [1:0] cmd_op;
    logic [AW-1:0] cmd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0; r_min_y <= '0; r_min_z <= '0;
            r_width_x <= 31'd65536; r_width_y <= 31'd65536; r_width_z <= 31'd65536;
            r_bin_counts <= 15'd16912;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                u3hb_pkg::CFG_MIN_X:   r_min_x <= i_cfg_data;
                u3hb_pkg::CFG_MIN_Y:   r_min_y <= i_cfg_data;
                u3hb_pkg::CFG_MIN_Z:   r_min_z <= i_cfg_data;
                u3hb_pkg::CFG_WIDTH_X: r_width_x <= i_cfg_data[30:0];
                u3hb_pkg::CFG_WIDTH_Y: r_width_y <= i_cfg_data[30:0];
                u3hb_pkg::CFG_WIDTH_Z: r_width_z <= i_cfg_data[30:0];
                u3hb_pkg::CFG_BCOUNTS: r_bin_counts <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    u3hb_front #(.MAX_BINS_X(MAX_BINS_X), .MAX_BINS_Y(MAX_BINS_Y),
                 .MAX_BINS_Z(MAX_BINS_Z), .AW(AW)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_action,
        .i_coord_x, .i_coord_y, .i_coord_z, .i_read_bin_x, .i_read_bin_y, .i_read_bin_z,
        .i_min_x(r_min_x), .i_min_y(r_min_y), .i_min_z(r_min_z),
        .i_width_x(r_width_x), .i_width_y(r_width_y), .i_width_z(r_width_z),
        .i_bin_counts(r_bin_counts), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready),
        .o_cmd_op(cmd_op), .o_cmd_ok(cmd_ok), .o_cmd_addr(cmd_addr)
    );

    u3hb_back #(.AW(AW), .DEPTH(DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd_op(cmd_op), .i_cmd_ok(cmd_ok), .i_cmd_addr(cmd_addr),
        .o_empty(empty), .i_pop(pop), .o_hit, .o_bin_count,
        .o_binned_total, .o_missed_total
    );
endmodule

/* rtl/core/u3hb_front.sv */
// front part: accepts items, divides the three axes bit-serially, classifies hit or miss
module u3hb_front #(
    parameter int MAX_BINS_X = u3hb_pkg::MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = u3hb_pkg::MAX_BINS_Y_DEF,
    parameter int MAX_BINS_Z = u3hb_pkg::MAX_BINS_Z_DEF,
    parameter int AW = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [1:0]                        i_action,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_coord_z,
    input  logic [u3hb_pkg::RIDX_W-1:0]       i_read_bin_x,
    input  logic [u3hb_pkg::RIDX_W-1:0]       i_read_bin_y,
    input  logic [u3hb_pkg::RIDX_W-1:0]       i_read_bin_z,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_min_x,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_min_y,
    input  logic signed [u3hb_pkg::COORD_W-1:0] i_min_z,
    input  logic [u3hb_pkg::WIDTH_W-1:0]      i_width_x,
    input  logic [u3hb_pkg::WIDTH_W-1:0]      i_width_y,
    input  logic [u3hb_pkg::WIDTH_W-1:0]      i_width_z,
    input  logic [u3hb_pkg::BCNT_W-1:0]       i_bin_counts,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output logic [1:0]                        o_cmd_op,
    output logic                              o_cmd_ok,
    output logic [AW-1:0]                     o_cmd_addr
);
    localparam int QW = u3hb_pkg::QUO_W;
    localparam int WW = u3hb_pkg::WIDTH_W;
    localparam int SW = $clog2(QW + 1);
    localparam int RIDX_W_L = u3hb_pkg::RIDX_W;

    u3hb_pkg::t_front_state r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic [1:0]    r_op;
    logic [QW-1:0] r_qx, r_qy, r_qz;
    logic [WW:0]   r_rx, r_ry, r_rz;
    logic          r_negx, r_negy, r_negz;
    logic [RIDX_W_L-1:0] r_rbx, r_rby, r_rbz;

    logic [QW:0]   dx, dy, dz;
    logic [WW:0]   sx, sy, sz;
    logic [WW+1:0] tx, ty, tz;

    logic [5:0] cnt_x, cnt_y, cnt_z;
    logic okx, oky, okz, rdok;
    logic [AW+8:0] bin_addr, rd_addr;

    function automatic logic [5:0] clampc(input logic [4:0] c, input int maxb);
        clampc = (32'(c) > maxb) ? 6'(maxb) : {1'b0, c};
    endfunction

    always_comb begin
        dx = {{2{i_coord_x[31]}}, i_coord_x} - {{2{i_min_x[31]}}, i_min_x};
        dy = {{2{i_coord_y[31]}}, i_coord_y} - {{2{i_min_y[31]}}, i_min_y};
        dz = {{2{i_coord_z[31]}}, i_coord_z} - {{2{i_min_z[31]}}, i_min_z};
        // restoring divide step
        sx = {r_rx[WW-1:0], r_qx[QW-1]};
        sy = {r_ry[WW-1:0], r_qy[QW-1]};
        sz = {r_rz[WW-1:0], r_qz[QW-1]};
        tx = {1'b0, sx} - {2'b0, i_width_x};
        ty = {1'b0, sy} - {2'b0, i_width_y};
        tz = {1'b0, sz} - {2'b0, i_width_z};
        cnt_x = clampc(i_bin_counts[4:0], MAX_BINS_X);
        cnt_y = clampc(i_bin_counts[9:5], MAX_BINS_Y);
        cnt_z = clampc(i_bin_counts[14:10], MAX_BINS_Z);
        okx = !r_negx && (i_width_x != '0) && (r_qx < QW'(cnt_x));
        oky = !r_negy && (i_width_y != '0) && (r_qy < QW'(cnt_y));
        okz = !r_negz && (i_width_z != '0) && (r_qz < QW'(cnt_z));
        bin_addr = ((r_qx[AW+8:0] * (AW+9)'(MAX_BINS_Y)) + r_qy[AW+8:0])
                   * (AW+9)'(MAX_BINS_Z) + r_qz[AW+8:0];
        rdok = (32'(r_rbx) < MAX_BINS_X) && (32'(r_rby) < MAX_BINS_Y)
               && (32'(r_rbz) < MAX_BINS_Z);
        rd_addr = (((AW+9)'(r_rbx) * (AW+9)'(MAX_BINS_Y)) + (AW+9)'(r_rby))
                  * (AW+9)'(MAX_BINS_Z) + (AW+9)'(r_rbz);
    end

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        o_full = (r_state != u3hb_pkg::ST_IDLE);
        o_cmd_valid = (r_state == u3hb_pkg::ST_EXEC);
        o_cmd_op = r_op;
        o_cmd_ok = 1'b0;
        o_cmd_addr = '0;
        if (r_op == u3hb_pkg::ACT_BIN) begin
            o_cmd_ok = okx && oky && okz;
            o_cmd_addr = bin_addr[AW-1:0];
        end else if (r_op == u3hb_pkg::ACT_READ) begin
            o_cmd_ok = rdok;
            o_cmd_addr = rd_addr[AW-1:0];
        end
        case (r_state)
            u3hb_pkg::ST_IDLE: begin
                if (i_push) begin
                    n_step = '0;
                    n_state = (i_action == u3hb_pkg::ACT_BIN) ? u3hb_pkg::ST_DIV
                                                              : u3hb_pkg::ST_EXEC;
                end
            end
            u3hb_pkg::ST_DIV: begin
                n_step = r_step + SW'(1);
                if (r_step == SW'(QW - 1)) n_state = u3hb_pkg::ST_EXEC;
            end
            u3hb_pkg::ST_EXEC: begin
                if (i_cmd_ready) n_state = u3hb_pkg::ST_IDLE;
            end
            default: n_state = u3hb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u3hb_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == u3hb_pkg::ST_IDLE && i_push) begin
            r_op <= i_action;
            r_negx <= dx[QW]; r_negy <= dy[QW]; r_negz <= dz[QW];
            r_qx <= dx[QW-1:0]; r_qy <= dy[QW-1:0]; r_qz <= dz[QW-1:0];
            r_rx <= '0; r_ry <= '0; r_rz <= '0;
            r_rbx <= i_read_bin_x; r_rby <= i_read_bin_y; r_rbz <= i_read_bin_z;
        end else if (r_state == u3hb_pkg::ST_DIV) begin
            r_rx <= tx[WW+1] ? sx : tx[WW:0];
            r_ry <= ty[WW+1] ? sy : ty[WW:0];
            r_rz <= tz[WW+1] ? sz : tz[WW:0];
            r_qx <= {r_qx[QW-2:0], !tx[WW+1]};
            r_qy <= {r_qy[QW-2:0], !ty[WW+1]};
            r_qz <= {r_qz[QW-2:0], !tz[WW+1]};
        end
    end

`ifndef ASSERT_OFF
    a_valid_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> o_full) else $error("cmd valid while idle");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u3hb_pkg::ST_DIV) |-> (r_step < SW'(QW))) else $error("divide overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && !i_cmd_ready) |=> o_cmd_valid) else $error("cmd dropped");
`endif
endmodule

/* rtl/core/u3hb_back.sv */
// back part: bin memory read-modify-write, clear sweep, counters and result register
module u3hb_back #(
    parameter int AW = 12,
    parameter int DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic [1:0]                  i_cmd_op,
    input  logic                        i_cmd_ok,
    input  logic [AW-1:0]               i_cmd_addr,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic                        o_hit,
    output logic [u3hb_pkg::CNT_W-1:0]  o_bin_count,
    output logic [u3hb_pkg::CNT_W-1:0]  o_binned_total,
    output logic [u3hb_pkg::CNT_W-1:0]  o_missed_total
);
    localparam int CW = u3hb_pkg::CNT_W;

    logic [CW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_rdata;
    logic [AW:0]   r_clr;
    logic          r_clearing;
    logic [1:0]    r_ph;
    logic [1:0]    r_op;
    logic          r_ok;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_binned, r_missed;
    logic          r_full;
    logic          busy;

    assign busy = r_clearing || (r_ph != 2'd0);
    assign o_cmd_ready = !busy && !r_full;
    assign o_empty = !r_full;

    always_ff @(posedge i_clk) begin
        if (r_clearing) r_mem[r_clr[AW-1:0]] <= '0;
        else if (r_ph == 2'd2 && r_op == u3hb_pkg::ACT_BIN && r_ok)
            r_mem[r_addr] <= u3hb_pkg::sat_inc(r_rdata);
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && o_cmd_ready) begin
            r_op <= i_cmd_op; r_ok <= i_cmd_ok; r_addr <= i_cmd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr <= '0;
            r_ph <= 2'd0;
            r_full <= 1'b0;
            r_binned <= '0;
            r_missed <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + (AW+1)'(1);
                if (r_clr == (AW+1)'(DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (r_full && i_pop) r_full <= 1'b0;
            if (i_cmd_valid && o_cmd_ready) r_ph <= 2'd1;
            else if (r_ph == 2'd1) r_ph <= 2'd2;
            else if (r_ph == 2'd2) begin
                r_ph <= 2'd0;
                r_full <= 1'b1;
                o_hit <= (r_op == u3hb_pkg::ACT_BIN) && r_ok;
                o_bin_count <= ((r_op == u3hb_pkg::ACT_READ) && r_ok) ? r_rdata : '0;
                case (r_op)
                    u3hb_pkg::ACT_BIN: begin
                        if (r_ok) begin
                            r_binned <= u3hb_pkg::sat_inc(r_binned);
                            o_binned_total <= u3hb_pkg::sat_inc(r_binned);
                            o_missed_total <= r_missed;
                        end else begin
                            r_missed <= u3hb_pkg::sat_inc(r_missed);
                            o_missed_total <= u3hb_pkg::sat_inc(r_missed);
                            o_binned_total <= r_binned;
                        end
                    end
                    u3hb_pkg::ACT_CLEAR: begin
                        r_clearing <= 1'b1;
                        r_clr <= '0;
                        r_binned <= '0; r_missed <= '0;
                        o_binned_total <= '0; o_missed_total <= '0;
                    end
                    u3hb_pkg::ACT_READ: begin
                        o_binned_total <= r_binned; o_missed_total <= r_missed;
                    end
                    default: begin
                        o_binned_total <= r_binned; o_missed_total <= r_missed;
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_cmd_ready) else $error("accept during clear");
    a_ph_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == 2'd1) |=> (r_ph == 2'd2)) else $error("rmw sequence broken");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_pop) |=> $stable(o_binned_total)) else $error("result changed");
`endif
endmodule
